FILE: src/uartrb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// uartrb_pkg
// Shared types and constants for the UART transmit/receive ring buffers.
// ============================================================================
package uartrb_pkg;

    // Ring geometry
    localparam int DEPTH = 32;
    localparam int PTR_W = $clog2(DEPTH);

    // Field widths
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_HOST_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HOST_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HOST_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TX_EMPTY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RX_BYTE    = 3'd4;

    // One input transaction
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] data_byte;
        logic              rx_error;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               write_accepted;
        logic [BYTE_W-1:0]  read_data;
        logic [COUNT_W-1:0] rx_count;
        logic               tx_request_enabled;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the item and read both rings
        logic commit;   // update the rings and load the result register
    } ctrl_t;

endpackage

FILE: src/uartrb_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// uartrb_ctrl
// Sequencer: accepts one transaction, executes it, and holds the result
// handshake.
// ============================================================================
module uartrb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output uartrb_pkg::ctrl_t   ctrl
);
    import uartrb_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    // Decode handshake and next state
    always_comb
    begin
        state_next   = state_reg;
        ctrl.capture = 1'b0;
        ctrl.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Hold until the result register is free
                if (!result_valid_reg || result_ready)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctrl.commit)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

    // A committed transaction is always presented next cycle
    a_commit_presents: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> result_valid)
        else $error("committed result not presented");

    // A captured transaction is held for execution in the following cycle
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> !item_ready)
        else $error("captured transaction not held for execution");

    // A pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !ctrl.commit)
        else $error("result overwritten while stalled");

endmodule

FILE: src/uartrb_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// uartrb_dp
// Datapath: transmit and receive rings, pointers, request enable and the
// result register.
// ============================================================================
module uartrb_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  uartrb_pkg::ctrl_t   ctrl,
    input  uartrb_pkg::item_t   item,
    output uartrb_pkg::result_t result
);
    import uartrb_pkg::*;

    // Ring storage
    logic [BYTE_W-1:0] tx_mem [DEPTH];
    logic [BYTE_W-1:0] rx_mem [DEPTH];
    logic [DEPTH-1:0]  rx_written_reg;
    logic [DEPTH-1:0]  rx_written_next;

    // Latched transaction and read data
    item_t             item_reg;
    logic [BYTE_W-1:0] tx_rd_data_reg;
    logic [BYTE_W-1:0] rx_rd_data_reg;
    logic              rx_rd_written_reg;

    // Control state
    logic [PTR_W-1:0] tx_wp_reg, tx_wp_next;
    logic [PTR_W-1:0] tx_rp_reg, tx_rp_next;
    logic [PTR_W-1:0] tx_pend_reg, tx_pend_next;
    logic [PTR_W-1:0] rx_wp_reg, rx_wp_next;
    logic [PTR_W-1:0] rx_rp_reg, rx_rp_next;
    logic             tx_req_reg, tx_req_next;

    result_t          result_reg, result_next;
    logic             tx_wr_en;
    logic             rx_wr_en;
    logic [BYTE_W-1:0] rx_byte;

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    function automatic logic [PTR_W:0] ring_gap(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
        if (wp >= rp)
            return {1'b0, wp} - {1'b0, rp};
        else
            return {1'b0, wp} + (PTR_W + 1)'(DEPTH) - {1'b0, rp};
    endfunction

    // Stale entries that were never written read as zero
    assign rx_byte = rx_rd_written_reg ? rx_rd_data_reg : '0;

    // Execute the latched transaction
    always_comb
    begin
        tx_wp_next      = tx_wp_reg;
        tx_rp_next      = tx_rp_reg;
        tx_pend_next    = tx_pend_reg;
        rx_wp_next      = rx_wp_reg;
        rx_rp_next      = rx_rp_reg;
        tx_req_next     = tx_req_reg;
        rx_written_next = rx_written_reg;
        tx_wr_en        = 1'b0;
        rx_wr_en        = 1'b0;
        result_next     = '0;

        case (item_reg.command)
            CMD_HOST_WRITE:
            begin
                if (tx_pend_reg < PTR_W'(DEPTH - 1))
                begin
                    tx_wr_en                   = 1'b1;
                    tx_wp_next                 = ring_advance(tx_wp_reg);
                    tx_pend_next               = tx_pend_reg + 1'b1;
                    tx_req_next                = 1'b1;
                    result_next.write_accepted = 1'b1;
                end
            end
            CMD_HOST_POP:
            begin
                result_next.read_data = rx_byte;
                rx_rp_next            = ring_advance(rx_rp_reg);
            end
            CMD_HOST_PEEK:
            begin
                result_next.read_data = rx_byte;
            end
            CMD_TX_EMPTY:
            begin
                if (tx_req_reg)
                begin
                    if (tx_pend_reg != '0)
                    begin
                        tx_pend_next         = tx_pend_reg - 1'b1;
                        tx_rp_next           = ring_advance(tx_rp_reg);
                        result_next.tx_valid = 1'b1;
                        result_next.tx_byte  = tx_rd_data_reg;
                    end
                    else
                    begin
                        tx_req_next = 1'b0;
                    end
                end
            end
            CMD_RX_BYTE:
            begin
                if (!item_reg.rx_error)
                begin
                    rx_wr_en                   = 1'b1;
                    rx_written_next[rx_wp_reg] = 1'b1;
                    rx_wp_next                 = ring_advance(rx_wp_reg);
                end
            end
            default:
            begin
                // Unused codes change nothing
            end
        endcase

        result_next.rx_count           = COUNT_W'(ring_gap(rx_wp_next, rx_rp_next));
        result_next.tx_request_enabled = tx_req_next;
    end

    // Ring memories: write on commit, registered read on capture
    always_ff @(posedge clk)
    begin
        if (ctrl.commit && tx_wr_en)
            tx_mem[tx_wp_reg] <= item_reg.data_byte;
        if (ctrl.commit && rx_wr_en)
            rx_mem[rx_wp_reg] <= item_reg.data_byte;
        if (ctrl.capture)
        begin
            item_reg       <= item;
            tx_rd_data_reg <= tx_mem[tx_rp_reg];
            rx_rd_data_reg <= rx_mem[rx_rp_reg];
        end
        if (ctrl.commit)
            result_reg <= result_next;
    end

    // Pointers, count, request enable and written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_wp_reg         <= '0;
            tx_rp_reg         <= '0;
            tx_pend_reg       <= '0;
            rx_wp_reg         <= '0;
            rx_rp_reg         <= '0;
            tx_req_reg        <= 1'b1;
            rx_written_reg    <= '0;
            rx_rd_written_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
                rx_rd_written_reg <= rx_written_reg[rx_rp_reg];
            if (ctrl.commit)
            begin
                tx_wp_reg      <= tx_wp_next;
                tx_rp_reg      <= tx_rp_next;
                tx_pend_reg    <= tx_pend_next;
                rx_wp_reg      <= rx_wp_next;
                rx_rp_reg      <= rx_rp_next;
                tx_req_reg     <= tx_req_next;
                rx_written_reg <= rx_written_next;
            end
        end
    end

    assign result = result_reg;

    // Pending count always matches the transmit pointer distance
    a_tx_pend_gap: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, tx_pend_reg} == ring_gap(tx_wp_reg, tx_rp_reg))
        else $error("transmit pending count out of step with pointers");

    // An accepted host write leaves the request enabled
    a_write_enables: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.commit && result_next.write_accepted) |=> tx_req_reg)
        else $error("request not enabled after accepted write");

    // Ring state moves only on commit
    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.commit |=> ($stable(rx_wp_reg) && $stable(rx_rp_reg)
                          && $stable(tx_pend_reg)))
        else $error("ring state changed outside commit");

endmodule

FILE: src/uart_tx_rx_ring_buffers.sv
`timescale 1ns / 1ps
// ============================================================================
// uart_tx_rx_ring_buffers
// UART transmit and receive ring buffers with host write, pop, peek,
// transmit-empty and receive-byte transactions.
// ============================================================================
//
//  Channel   Direction  Handshake                    Payload
//  item      in         item_valid / item_ready      item_t   (command, byte, error)
//  result    out        result_valid / result_ready  result_t (one per item)
//
//  Each transaction has an accept cycle that latches the item and
//  registers the read ports of both rings, then an execute cycle that updates
//  the rings and loads the result register.
//  The execute cycle waits while an earlier result is still unclaimed; a new
//  item is taken while the previous result waits.
//  Reset clears all pointers and the receive written flags (unwritten receive
//  entries read as zero) and sets the transmit request enable; no clearing
//  pass is needed.
// ============================================================================
module uart_tx_rx_ring_buffers (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  uartrb_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output uartrb_pkg::result_t result
);
    import uartrb_pkg::*;

    ctrl_t ctrl;

    // Sequencer
    uartrb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ctrl         (ctrl)
    );

    // Rings and result register
    uartrb_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .result (result)
    );

endmodule
